// File: rtl/sfst_pkg.sv
`default_nettype none

package sfst_pkg;

  // Field widths of one transaction
  localparam int unsigned AddrW     = 8;
  localparam int unsigned FuncIdxW  = 5;
  localparam int unsigned MaskW     = 32;
  localparam int unsigned OpW       = 2;
  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutDataW  = 8;

  // Operation codes carried in tuser
  typedef enum logic [OpW-1:0] {
    OP_SET   = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DECODE = 2'd1,
    ST_SCAN   = 2'd2,
    ST_DONE   = 2'd3
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // latch the incoming transaction, restart the scan
    logic scan;       // issue the next table read
    logic clear_tbl;  // empty the table
    logic res_we;     // capture the result
    logic update;     // write the set result into the table
    logic out_load;   // move the result into the output register
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [OpW-1:0] op;
    logic           acked;
    logic           hit;
    logic           miss;
    logic           out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/sfst_ctrl.sv
`default_nettype none

module sfst_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire sfst_pkg::dp_sts_t sts_i,
  output sfst_pkg::dp_cmd_t     cmd_o
);
  import sfst_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if ((sts_i.op == OP_SET && sts_i.acked) || sts_i.op == OP_QUERY) begin
          state_d = ST_SCAN;
        end else begin
          cmd_o.res_we    = 1'b1;
          cmd_o.clear_tbl = (sts_i.op == OP_CLEAR);
          state_d         = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (sts_i.hit || sts_i.miss) begin
          cmd_o.res_we = 1'b1;
          cmd_o.update = (sts_i.op == OP_SET);
          state_d      = ST_DONE;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/sfst_dpath.sv
`default_nettype none

module sfst_dpath #(
  parameter int unsigned MAX_ENTRIES = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [sfst_pkg::InDataW-1:0]      in_data_i,
  input  wire logic [sfst_pkg::OpW-1:0]          in_user_i,
  input  wire sfst_pkg::dp_cmd_t                 cmd_i,
  output sfst_pkg::dp_sts_t                      sts_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [sfst_pkg::OutDataW-1:0]          out_data_o
);
  import sfst_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  // Table storage
  logic [AddrW-1:0] addr_mem [MAX_ENTRIES];
  logic [MaskW-1:0] mask_mem [MAX_ENTRIES];

  // Latched transaction
  logic [OpW-1:0]      op_q;
  logic [AddrW-1:0]    key_q;
  logic [FuncIdxW-1:0] bit_q;
  logic                on_q;
  logic                ack_q;

  // Scan and table control
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rd_ptr_q, rd_ptr_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0] cmp_idx_q;
  logic [AddrW-1:0] addr_rd_q;
  logic [MaskW-1:0] mask_rd_q;

  // Result and output registers
  logic [2:0] res_q, res_d;
  logic       out_vld_q, out_vld_d;
  logic [2:0] out_q;

  logic            rd_en;
  logic            hit, miss, room;
  logic            wr_en, append;
  logic [IdxW-1:0] wr_idx;
  logic [MaskW-1:0] new_mask;

  // Lookup status
  assign rd_en  = cmd_i.scan && (rd_ptr_q < count_q);
  assign hit    = cmp_vld_q && (addr_rd_q == key_q);
  assign miss   = !cmp_vld_q && (rd_ptr_q >= count_q);
  assign room   = count_q < CntW'(MAX_ENTRIES);
  assign append = !hit && room;
  assign wr_en  = cmd_i.update && (hit || room);
  assign wr_idx = hit ? cmp_idx_q : count_q[IdxW-1:0];

  // Build the updated mask: a new entry starts cleared
  always_comb begin
    new_mask        = hit ? mask_rd_q : '0;
    new_mask[bit_q] = on_q;
  end

  // Result fields: function_on, success, stored from the lowest bit up
  always_comb begin
    res_d = res_q;
    if (cmd_i.res_we) begin
      res_d[0] = (op_q == OP_QUERY) && hit && mask_rd_q[bit_q];
      res_d[1] = (op_q == OP_QUERY) || (op_q == OP_CLEAR) || ((op_q == OP_SET) && ack_q);
      res_d[2] = (op_q == OP_SET) && ack_q && (hit || room);
    end
  end

  // Scan pointer, entry count and output handshake
  always_comb begin
    rd_ptr_d  = rd_ptr_q;
    cmp_vld_d = rd_en;
    count_d   = count_q;
    out_vld_d = out_vld_q;
    if (cmd_i.load) begin
      rd_ptr_d = '0;
    end else if (rd_en) begin
      rd_ptr_d = rd_ptr_q + CntW'(1);
    end
    if (cmd_i.clear_tbl) begin
      count_d = '0;
    end else if (wr_en && append) begin
      count_d = count_q + CntW'(1);
    end
    if (cmd_i.out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      rd_ptr_q  <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      rd_ptr_q  <= rd_ptr_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= in_data_i[AddrW-1:0];
      bit_q <= in_data_i[AddrW+FuncIdxW-1:AddrW];
      on_q  <= in_data_i[AddrW+FuncIdxW];
      ack_q <= in_data_i[AddrW+FuncIdxW+1];
      op_q  <= in_user_i;
    end
    if (rd_en) begin
      cmp_idx_q <= rd_ptr_q[IdxW-1:0];
    end
    res_q <= res_d;
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  // Table read port, registered data
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      addr_rd_q <= addr_mem[rd_ptr_q[IdxW-1:0]];
      mask_rd_q <= mask_mem[rd_ptr_q[IdxW-1:0]];
    end
  end

  // Table write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mask_mem[wr_idx] <= new_mask;
      if (append) begin
        addr_mem[wr_idx] <= key_q;
      end
    end
  end

  assign sts_o.op       = op_q;
  assign sts_o.acked    = ack_q;
  assign sts_o.hit      = hit;
  assign sts_o.miss     = miss;
  assign sts_o.out_free = !out_vld_q || out_ready_i;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = {{(OutDataW-3){1'b0}}, out_q};

endmodule

`default_nettype wire

// File: rtl/slave_function_state_table.sv
// Shadow table of function on/off bits, keyed by slave address.
// Input channel s_axis_*: one transaction per command. tuser holds the
// operation (set bit, query bit, clear table); tdata holds the slave address,
// function number, on/off value and bus acknowledge.
// Output channel m_axis_*: exactly one result transaction per command, with
// function_on, success and stored in tdata.
// A clear, an unacknowledged set or an unused operation goes from accept
// through decode straight to its result; a set or query instead scans the stored
// entries one per cycle until it hits the slave address or has read all N
// entries in the table (N <= MAX_ENTRIES); an empty table gives a miss with no read.
// The block accepts no new command until the previous one has moved its
// result to the output register; the sequential scan sets the time per command.
// A new command is accepted while the previous result still waits in the
// output register; when the receiver stalls, the finished result holds in
// the datapath result register until the output register frees, and no
// further command is accepted meanwhile.
// Reset empties the table at once; entry storage itself is not cleared.
`default_nettype none

module slave_function_state_table #(
  parameter int unsigned MAX_ENTRIES = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [7:0] slave_address, [12:8] function_index, [13] turn_on, [14] acked
  input  wire logic [sfst_pkg::InDataW-1:0]  s_axis_tdata_i,
  // [1:0] func
  input  wire logic [sfst_pkg::OpW-1:0]      s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [0] function_on, [1] success, [2] stored
  output logic [sfst_pkg::OutDataW-1:0]      m_axis_tdata_o
);
  import sfst_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  sfst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sfst_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire
